FILE: src/rhe_pkg.sv
// shared types and constants for the rgb histogram equalizer
package rhe_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned BINS       = 256;
  localparam int unsigned ADDR_W     = $clog2(BINS);
  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int unsigned PROD_W     = CNT_W + PIX_W;
  localparam int unsigned BIT_W      = $clog2(PIX_W);

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_COUNT = 2'd1;
  localparam logic [1:0] ACT_MAP   = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_WR,
    ST_BUILD,
    ST_BUILD_END,
    ST_MAP_RD,
    ST_MAP_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              load;
    logic              clr_wr;
    logic              clr_total;
    logic              cnt_rd;
    logic              cnt_wr;
    logic              bld_rd;
    logic              run_clr;
    logic              map_rd;
    logic              mul;
    logic              div_step;
    logic              out_load;
    logic [ADDR_W-1:0] idx;
    logic [BIT_W-1:0]  bit_idx;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic out_busy;
  } status_t;

endpackage

FILE: src/rhe_ctrl.sv
// sequencing state machine for the rgb histogram equalizer
module rhe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  rhe_pkg::in_t     in_data,
  output logic             in_stall,
  input  rhe_pkg::status_t status,
  output rhe_pkg::cmd_t    cmd
);

  rhe_pkg::state_t             state_r, state_nxt;
  logic [rhe_pkg::ADDR_W-1:0]  idx_r, idx_nxt;
  logic [rhe_pkg::BIT_W-1:0]   bit_r, bit_nxt;
  logic                        ready_r, ready_nxt;
  logic                        accept;

  assign in_stall = (state_r != rhe_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rhe_pkg::ST_CLEAR;
      idx_r   <= '0;
      bit_r   <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      bit_r   <= bit_nxt;
      ready_r <= ready_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    bit_nxt     = bit_r;
    ready_nxt   = ready_r;
    cmd         = '0;
    cmd.idx     = idx_r;
    cmd.bit_idx = bit_r;
    case (state_r)
      rhe_pkg::ST_CLEAR: begin
        cmd.clr_wr    = 1'b1;
        cmd.clr_total = 1'b1;
        ready_nxt     = 1'b0;
        idx_nxt       = idx_r + 1'b1;
        if (idx_r == '1) begin
          state_nxt = rhe_pkg::ST_IDLE;
        end
      end
      rhe_pkg::ST_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          cmd.load = 1'b1;
          case (in_data.action)
            rhe_pkg::ACT_CLEAR: begin
              state_nxt = rhe_pkg::ST_CLEAR;
            end
            rhe_pkg::ACT_COUNT: begin
              if (!status.full) begin
                cmd.cnt_rd = 1'b1;
                ready_nxt  = 1'b0;
                state_nxt  = rhe_pkg::ST_CNT_WR;
              end
            end
            rhe_pkg::ACT_MAP: begin
              if (ready_r) begin
                state_nxt = rhe_pkg::ST_MAP_RD;
              end else begin
                cmd.run_clr = 1'b1;
                state_nxt   = rhe_pkg::ST_BUILD;
              end
            end
            default: begin
              state_nxt = rhe_pkg::ST_IDLE;
            end
          endcase
        end
      end
      rhe_pkg::ST_CNT_WR: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = rhe_pkg::ST_IDLE;
      end
      rhe_pkg::ST_BUILD: begin
        cmd.bld_rd = 1'b1;
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == '1) begin
          state_nxt = rhe_pkg::ST_BUILD_END;
        end
      end
      rhe_pkg::ST_BUILD_END: begin
        ready_nxt = 1'b1;
        state_nxt = rhe_pkg::ST_MAP_RD;
      end
      rhe_pkg::ST_MAP_RD: begin
        cmd.map_rd = 1'b1;
        state_nxt  = rhe_pkg::ST_MAP_MUL;
      end
      rhe_pkg::ST_MAP_MUL: begin
        cmd.mul   = 1'b1;
        bit_nxt   = '1;
        state_nxt = rhe_pkg::ST_DIV;
      end
      rhe_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r - 1'b1;
        if (bit_r == '0) begin
          state_nxt = rhe_pkg::ST_DONE;
        end
      end
      rhe_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = rhe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rhe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/rhe_datapath.sv
// histogram memories, cumulative tables, scaling divider and output register
module rhe_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  rhe_pkg::in_t     in_data,
  input  rhe_pkg::cmd_t    cmd,
  output rhe_pkg::status_t status,
  output logic             out_valid,
  input  logic             out_stall,
  output rhe_pkg::out_t    out_data
);

  localparam int unsigned CW = rhe_pkg::CNT_W;
  localparam int unsigned PW = rhe_pkg::PROD_W;
  localparam int unsigned AW = rhe_pkg::ADDR_W;
  localparam int unsigned XW = rhe_pkg::PIX_W;

  logic [CW-1:0] cnt_red_mem [rhe_pkg::BINS];
  logic [CW-1:0] cnt_grn_mem [rhe_pkg::BINS];
  logic [CW-1:0] cnt_blu_mem [rhe_pkg::BINS];
  logic [CW-1:0] cum_red_mem [rhe_pkg::BINS];
  logic [CW-1:0] cum_grn_mem [rhe_pkg::BINS];
  logic [CW-1:0] cum_blu_mem [rhe_pkg::BINS];

  rhe_pkg::in_t  pix_r;
  logic [CW-1:0] rd_red_r, rd_grn_r, rd_blu_r;
  logic [CW-1:0] run_red_r, run_grn_r, run_blu_r;
  logic [CW-1:0] cum_red_r, cum_grn_r, cum_blu_r;
  logic [PW-1:0] rem_red_r, rem_grn_r, rem_blu_r;
  logic [XW-1:0] q_red_r, q_grn_r, q_blu_r;
  logic [CW-1:0] total_r;
  logic          bld_wr_r;
  logic [AW-1:0] bld_addr_r;
  logic          out_valid_r;
  rhe_pkg::out_t out_r;

  logic [AW-1:0] rd_a_red, rd_a_grn, rd_a_blu;
  logic [AW-1:0] wr_a_red, wr_a_grn, wr_a_blu;
  logic [CW-1:0] wd_red, wd_grn, wd_blu;
  logic [CW-1:0] sum_red, sum_grn, sum_blu;
  logic [PW-1:0] dshift;
  logic          cnt_we, cnt_re;

  assign cnt_re   = cmd.cnt_rd | cmd.bld_rd;
  assign cnt_we   = cmd.clr_wr | cmd.cnt_wr;
  assign rd_a_red = cmd.bld_rd ? cmd.idx : in_data.red_in;
  assign rd_a_grn = cmd.bld_rd ? cmd.idx : in_data.green_in;
  assign rd_a_blu = cmd.bld_rd ? cmd.idx : in_data.blue_in;
  assign wr_a_red = cmd.clr_wr ? cmd.idx : pix_r.red_in;
  assign wr_a_grn = cmd.clr_wr ? cmd.idx : pix_r.green_in;
  assign wr_a_blu = cmd.clr_wr ? cmd.idx : pix_r.blue_in;
  assign wd_red   = cmd.clr_wr ? '0 : rd_red_r + 1'b1;
  assign wd_grn   = cmd.clr_wr ? '0 : rd_grn_r + 1'b1;
  assign wd_blu   = cmd.clr_wr ? '0 : rd_blu_r + 1'b1;
  assign sum_red  = run_red_r + rd_red_r;
  assign sum_grn  = run_grn_r + rd_grn_r;
  assign sum_blu  = run_blu_r + rd_blu_r;
  assign dshift   = PW'(total_r) << cmd.bit_idx;

  // histogram memories
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_red_mem[wr_a_red] <= wd_red;
      cnt_grn_mem[wr_a_grn] <= wd_grn;
      cnt_blu_mem[wr_a_blu] <= wd_blu;
    end
    if (cnt_re) begin
      rd_red_r <= cnt_red_mem[rd_a_red];
      rd_grn_r <= cnt_grn_mem[rd_a_grn];
      rd_blu_r <= cnt_blu_mem[rd_a_blu];
    end
  end

  // cumulative tables
  always_ff @(posedge clk) begin
    if (bld_wr_r) begin
      cum_red_mem[bld_addr_r] <= sum_red;
      cum_grn_mem[bld_addr_r] <= sum_grn;
      cum_blu_mem[bld_addr_r] <= sum_blu;
    end
    if (cmd.map_rd) begin
      cum_red_r <= cum_red_mem[pix_r.red_in];
      cum_grn_r <= cum_grn_mem[pix_r.green_in];
      cum_blu_r <= cum_blu_mem[pix_r.blue_in];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bld_wr_r    <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      bld_wr_r <= cmd.bld_rd;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.clr_total) begin
        total_r <= '0;
      end else if (cmd.cnt_wr) begin
        total_r <= total_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bld_addr_r <= cmd.idx;
    if (cmd.load) begin
      pix_r <= in_data;
    end
    if (cmd.run_clr) begin
      run_red_r <= '0;
      run_grn_r <= '0;
      run_blu_r <= '0;
    end else if (bld_wr_r) begin
      run_red_r <= sum_red;
      run_grn_r <= sum_grn;
      run_blu_r <= sum_blu;
    end
    if (cmd.mul) begin
      rem_red_r <= {cum_red_r, XW'(0)} - PW'(cum_red_r);
      rem_grn_r <= {cum_grn_r, XW'(0)} - PW'(cum_grn_r);
      rem_blu_r <= {cum_blu_r, XW'(0)} - PW'(cum_blu_r);
      q_red_r   <= '0;
      q_grn_r   <= '0;
      q_blu_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_red_r >= dshift) begin
        rem_red_r            <= rem_red_r - dshift;
        q_red_r[cmd.bit_idx] <= 1'b1;
      end
      if (rem_grn_r >= dshift) begin
        rem_grn_r            <= rem_grn_r - dshift;
        q_grn_r[cmd.bit_idx] <= 1'b1;
      end
      if (rem_blu_r >= dshift) begin
        rem_blu_r            <= rem_blu_r - dshift;
        q_blu_r[cmd.bit_idx] <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      if (total_r == '0) begin
        out_r <= '0;
      end else begin
        out_r.red_out   <= q_red_r;
        out_r.green_out <= q_grn_r;
        out_r.blue_out  <= q_blu_r;
      end
    end
  end

  assign status.full     = (total_r >= CW'(rhe_pkg::MAX_PIXELS));
  assign status.out_busy = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_r;

endmodule

FILE: src/rgb_histogram_equalizer.sv
// rgb histogram equalizer top level
// count: read, write back +1; clear item: accept, then one histogram bin zeroed per cycle
// map item with tables ready: read, scale, 8 divide steps, then load into the output register
// first map item after counting first runs the cumulative table sweep
// one transaction at a time; the divider's 8 iterations and any output stall set the map rate
// after reset the histograms are cleared by a pass over all 256 bins before in_stall falls
module rgb_histogram_equalizer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rhe_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rhe_pkg::out_t out_data
);

  rhe_pkg::cmd_t    cmd;
  rhe_pkg::status_t status;

  rhe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rhe_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: src/rhe_checker.sv
// port-level checks for the rgb histogram equalizer
module rhe_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input rhe_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input rhe_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.action == rhe_pkg::ACT_CLEAR |=> in_stall)
    else $error("clear sweep not started");

  a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.action == rhe_pkg::ACT_MAP |=> in_stall)
    else $error("map transaction not in progress");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rgb_histogram_equalizer rhe_checker u_rhe_checker (.*);
